// ===== sv/va_pkg.sv =====
package va_pkg;

  localparam int unsigned DW   = 32;
  localparam int unsigned FRAC = 16;
  localparam int unsigned PW   = 2 * (DW + 1);
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned RW   = SW / 2;
  localparam int unsigned QW   = DW + FRAC;
  localparam int unsigned NMUL = 6;

  localparam logic [3:0] FN_ADD    = 4'd0;
  localparam logic [3:0] FN_SUB    = 4'd1;
  localparam logic [3:0] FN_NEGATE = 4'd2;
  localparam logic [3:0] FN_SCALE  = 4'd3;
  localparam logic [3:0] FN_DIVIDE = 4'd4;
  localparam logic [3:0] FN_DOT    = 4'd5;
  localparam logic [3:0] FN_CROSS  = 4'd6;
  localparam logic [3:0] FN_NORM   = 4'd7;
  localparam logic [3:0] FN_MAG    = 4'd8;
  localparam logic [3:0] FN_DIST   = 4'd9;
  localparam logic [3:0] FN_EQUAL  = 4'd10;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] val;
  } sat_t;

  typedef struct packed {
    logic [3:0]         func;
    logic               eq;
    logic [2:0][DW-1:0] a;
    logic [DW-1:0]      k;
    logic [2:0][DW-1:0] r;
    logic [DW-1:0]      rs;
    logic [1:0]         st;
  } item_t;

  // clip a wide signed value to 32 bits
  function automatic sat_t sat32(input logic signed [SW-1:0] v);
    sat_t s;
    s.hit = !((&v[SW-1:DW-1]) || !(|v[SW-1:DW-1]));
    if (s.hit) begin
      s.val = v[SW-1] ? S32_MIN : S32_MAX;
    end else begin
      s.val = v[DW-1:0];
    end
    return s;
  endfunction

endpackage

// ===== sv/va_front.sv =====
module va_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [3:0]                  in_func,
  input  logic [2:0][va_pkg::DW-1:0]  in_a,
  input  logic [2:0][va_pkg::DW-1:0]  in_b,
  input  logic [va_pkg::DW-1:0]       in_k,
  output logic                        out_vld,
  output va_pkg::item_t               out_item,
  output logic [va_pkg::SW-1:0]       out_rad
);

  localparam int unsigned DW = va_pkg::DW;
  localparam int unsigned PW = va_pkg::PW;
  localparam int unsigned SW = va_pkg::SW;

  logic signed [DW:0] ae [3];
  logic signed [DW:0] be [3];
  logic signed [DW:0] de [3];
  logic signed [DW:0] ke;

  logic signed [DW:0] op0_nxt [va_pkg::NMUL];
  logic signed [DW:0] op1_nxt [va_pkg::NMUL];
  logic signed [DW:0] op0_r   [va_pkg::NMUL];
  logic signed [DW:0] op1_r   [va_pkg::NMUL];
  logic signed [PW-1:0] p_r   [va_pkg::NMUL];
  logic signed [PW:0]   u_nxt [3];
  logic signed [PW:0]   u_r   [3];
  logic signed [SW-1:0] v_nxt [3];
  logic signed [SW-1:0] v_r   [3];

  va_pkg::item_t item_a_nxt, item_a_r, item_b_r, item_c_r, item_d_r;
  va_pkg::item_t item_e_nxt, item_e_r;
  logic [SW-1:0] rad_r;
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r, vld_e_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ae[i] = signed'({in_a[i][DW-1], in_a[i]});
      be[i] = signed'({in_b[i][DW-1], in_b[i]});
      de[i] = ae[i] - be[i];
    end
    ke = signed'({in_k[DW-1], in_k});
  end

  // stage A: add/sub/negate and multiplier operand select
  always_comb begin
    va_pkg::sat_t s;
    logic hit;
    s          = '0;
    hit        = 1'b0;
    item_a_nxt = '0;
    item_a_nxt.func = in_func;
    item_a_nxt.eq   = (in_a == in_b);
    item_a_nxt.a    = in_a;
    item_a_nxt.k    = in_k;
    for (int i = 0; i < va_pkg::NMUL; i++) begin
      op0_nxt[i] = '0;
      op1_nxt[i] = '0;
    end
    case (in_func)
      va_pkg::FN_ADD: begin
        for (int i = 0; i < 3; i++) begin
          s = va_pkg::sat32(SW'(ae[i]) + SW'(be[i]));
          item_a_nxt.r[i] = s.val;
          hit = hit | s.hit;
        end
      end
      va_pkg::FN_SUB: begin
        for (int i = 0; i < 3; i++) begin
          s = va_pkg::sat32(SW'(de[i]));
          item_a_nxt.r[i] = s.val;
          hit = hit | s.hit;
        end
      end
      va_pkg::FN_NEGATE: begin
        for (int i = 0; i < 3; i++) begin
          s = va_pkg::sat32(-SW'(ae[i]));
          item_a_nxt.r[i] = s.val;
          hit = hit | s.hit;
        end
      end
      va_pkg::FN_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          op0_nxt[i] = ae[i];
          op1_nxt[i] = ke;
        end
      end
      va_pkg::FN_DOT: begin
        for (int i = 0; i < 3; i++) begin
          op0_nxt[i] = ae[i];
          op1_nxt[i] = be[i];
        end
      end
      va_pkg::FN_CROSS: begin
        op0_nxt[0] = ae[1]; op1_nxt[0] = be[2];
        op0_nxt[1] = be[1]; op1_nxt[1] = ae[2];
        op0_nxt[2] = be[0]; op1_nxt[2] = ae[2];
        op0_nxt[3] = ae[0]; op1_nxt[3] = be[2];
        op0_nxt[4] = ae[0]; op1_nxt[4] = be[1];
        op0_nxt[5] = be[0]; op1_nxt[5] = ae[1];
      end
      va_pkg::FN_NORM, va_pkg::FN_MAG: begin
        for (int i = 0; i < 3; i++) begin
          op0_nxt[i] = ae[i];
          op1_nxt[i] = ae[i];
        end
      end
      va_pkg::FN_DIST: begin
        for (int i = 0; i < 3; i++) begin
          op0_nxt[i] = de[i];
          op1_nxt[i] = de[i];
        end
      end
      default: begin
      end
    endcase
    item_a_nxt.st = hit ? va_pkg::ST_SAT : va_pkg::ST_OK;
  end

  // stage C: pairwise combine
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = (PW+1)'(p_r[i]);
    end
    case (item_b_r.func)
      va_pkg::FN_CROSS: begin
        u_nxt[0] = (PW+1)'(p_r[0]) - (PW+1)'(p_r[1]);
        u_nxt[1] = (PW+1)'(p_r[2]) - (PW+1)'(p_r[3]);
        u_nxt[2] = (PW+1)'(p_r[4]) - (PW+1)'(p_r[5]);
      end
      va_pkg::FN_DOT, va_pkg::FN_NORM, va_pkg::FN_MAG, va_pkg::FN_DIST: begin
        u_nxt[0] = (PW+1)'(p_r[0]) + (PW+1)'(p_r[1]);
        u_nxt[1] = (PW+1)'(p_r[2]);
        u_nxt[2] = '0;
      end
      default: begin
      end
    endcase
  end

  // stage D: final sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_nxt[i] = SW'(u_r[i]);
    end
    case (item_c_r.func)
      va_pkg::FN_DOT, va_pkg::FN_NORM, va_pkg::FN_MAG, va_pkg::FN_DIST: begin
        v_nxt[0] = SW'(u_r[0]) + SW'(u_r[1]);
      end
      default: begin
      end
    endcase
  end

  // stage E: floor to Q16.16 and clip
  always_comb begin
    va_pkg::sat_t s;
    logic hit;
    s          = '0;
    hit        = 1'b0;
    item_e_nxt = item_d_r;
    case (item_d_r.func)
      va_pkg::FN_SCALE, va_pkg::FN_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          s = va_pkg::sat32(v_r[i] >>> va_pkg::FRAC);
          item_e_nxt.r[i] = s.val;
          hit = hit | s.hit;
        end
      end
      va_pkg::FN_DOT: begin
        s = va_pkg::sat32(v_r[0] >>> va_pkg::FRAC);
        item_e_nxt.rs = s.val;
        hit = s.hit;
      end
      default: begin
      end
    endcase
    if (hit) begin
      item_e_nxt.st = va_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    item_a_r <= item_a_nxt;
    item_b_r <= item_a_r;
    item_c_r <= item_b_r;
    item_d_r <= item_c_r;
    item_e_r <= item_e_nxt;
    for (int i = 0; i < va_pkg::NMUL; i++) begin
      op0_r[i] <= op0_nxt[i];
      op1_r[i] <= op1_nxt[i];
      p_r[i]   <= op0_r[i] * op1_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      u_r[i] <= u_nxt[i];
      v_r[i] <= v_nxt[i];
    end
    rad_r <= v_r[0];
  end

  assign out_vld  = vld_e_r;
  assign out_item = item_e_r;
  assign out_rad  = rad_r;

endmodule

// ===== sv/va_sqrt.sv =====
module va_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [va_pkg::SW-1:0]    in_rad,
  input  va_pkg::item_t            in_item,
  output logic                     out_vld,
  output logic [va_pkg::RW-1:0]    out_root,
  output va_pkg::item_t            out_item
);

  localparam int unsigned SW = va_pkg::SW;
  localparam int unsigned RW = va_pkg::RW;

  logic               vld_r  [RW];
  logic [SW-1:0]      rad_r  [RW];
  logic [RW+1:0]      rem_r  [RW];
  logic [RW-1:0]      root_r [RW];
  va_pkg::item_t      item_r [RW];

  // one root bit per stage
  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic          vld_i;
    logic [SW-1:0] rad_i;
    logic [RW+1:0] rem_i;
    logic [RW-1:0] root_i;
    va_pkg::item_t item_i;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          fit;

    if (g == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign item_i = in_item;
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign item_i = item_r[g-1];
    end

    assign cur   = {rem_i, rad_i[SW-1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign fit   = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[g]  <= {rad_i[SW-3:0], 2'b00};
      rem_r[g]  <= fit ? (RW+2)'(cur - trial) : cur[RW+1:0];
      root_r[g] <= {root_i[RW-2:0], fit};
      item_r[g] <= item_i;
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_item = item_r[RW-1];

endmodule

// ===== sv/va_div.sv =====
module va_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [va_pkg::RW-1:0]       in_root,
  input  va_pkg::item_t               in_item,
  output logic                        out_vld,
  output logic [2:0][va_pkg::QW-1:0]  out_q,
  output logic [2:0]                  out_neg,
  output va_pkg::item_t               out_item
);

  localparam int unsigned DW = va_pkg::DW;
  localparam int unsigned QW = va_pkg::QW;
  localparam int unsigned SW = va_pkg::SW;

  va_pkg::item_t      item_nxt, pitem_r;
  logic [DW-1:0]      dvs_nxt, pdvs_r;
  logic [2:0][QW-1:0] dvd_nxt, pdvd_r;
  logic [2:0]         neg_nxt, pneg_r;
  logic               pvld_r;

  logic               vld_r  [QW];
  logic [DW-1:0]      dvs_r  [QW];
  logic [2:0][DW-1:0] rem_r  [QW];
  logic [2:0][QW-1:0] dq_r   [QW];
  logic [2:0]         neg_r  [QW];
  va_pkg::item_t      item_r [QW];

  // operand prep; magnitude and distance roots are final here
  always_comb begin
    va_pkg::sat_t s;
    logic k_neg;
    logic is_div;
    logic [DW-1:0] mag;
    s        = va_pkg::sat32(signed'(SW'(in_root)));
    is_div   = (in_item.func == va_pkg::FN_DIVIDE);
    k_neg    = is_div && in_item.k[DW-1];
    item_nxt = in_item;
    mag      = '0;
    if (is_div) begin
      dvs_nxt = in_item.k[DW-1] ? DW'(-in_item.k) : in_item.k;
    end else begin
      dvs_nxt = in_root[DW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      mag        = in_item.a[i][DW-1] ? DW'(-in_item.a[i]) : in_item.a[i];
      dvd_nxt[i] = {mag, {va_pkg::FRAC{1'b0}}};
      neg_nxt[i] = in_item.a[i][DW-1] ^ k_neg;
    end
    if (in_item.func == va_pkg::FN_MAG || in_item.func == va_pkg::FN_DIST) begin
      item_nxt.rs = s.val;
      item_nxt.st = s.hit ? va_pkg::ST_SAT : va_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pitem_r <= item_nxt;
    pdvs_r  <= dvs_nxt;
    pdvd_r  <= dvd_nxt;
    pneg_r  <= neg_nxt;
  end

  // restoring division, one quotient bit per stage on three lanes
  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic               vld_i;
    logic [DW-1:0]      dvs_i;
    logic [2:0][DW-1:0] rem_i;
    logic [2:0][QW-1:0] dq_i;
    logic [2:0]         neg_i;
    va_pkg::item_t      item_i;
    logic [2:0][DW-1:0] rem_nxt;
    logic [2:0][QW-1:0] dq_nxt;

    if (g == 0) begin : g_first
      assign vld_i  = pvld_r;
      assign dvs_i  = pdvs_r;
      assign rem_i  = '0;
      assign dq_i   = pdvd_r;
      assign neg_i  = pneg_r;
      assign item_i = pitem_r;
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign dvs_i  = dvs_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign dq_i   = dq_r[g-1];
      assign neg_i  = neg_r[g-1];
      assign item_i = item_r[g-1];
    end

    always_comb begin
      logic [DW:0] cur;
      logic        fit;
      cur = '0;
      fit = 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur        = {rem_i[i], dq_i[i][QW-1]};
        fit        = (cur >= {1'b0, dvs_i});
        rem_nxt[i] = fit ? DW'(cur - {1'b0, dvs_i}) : cur[DW-1:0];
        dq_nxt[i]  = {dq_i[i][QW-2:0], fit};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      dvs_r[g]  <= dvs_i;
      rem_r[g]  <= rem_nxt;
      dq_r[g]   <= dq_nxt;
      neg_r[g]  <= neg_i;
      item_r[g] <= item_i;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_q    = dq_r[QW-1];
  assign out_neg  = neg_r[QW-1];
  assign out_item = item_r[QW-1];

endmodule

// ===== sv/vector3_alu_core.sv =====
// Fully pipelined Q16.16 3D vector unit. A request is taken on every clock where start is
// high; busy is always low. Each request yields exactly one result, shown on the out_ ports
// for the single cycle in which out_valid is high. A request passes through operand select,
// multiply and sum, then square root (one root bit per stage), then division (one quotient
// bit per stage) and one output register. Latency is the same for every opcode, so results
// leave in request order. The receiver cannot stall the unit and must take each result as
// it appears.
module vector3_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_func,
  input  logic [31:0] in_ax,
  input  logic [31:0] in_ay,
  input  logic [31:0] in_az,
  input  logic [31:0] in_bx,
  input  logic [31:0] in_by_comp,
  input  logic [31:0] in_bz,
  input  logic [31:0] in_scalar_k,
  output logic        out_valid,
  output logic [31:0] out_rx,
  output logic [31:0] out_ry,
  output logic [31:0] out_rz,
  output logic [31:0] out_rscalar,
  output logic        out_equal_flag,
  output logic [1:0]  out_status
);

  localparam int unsigned DW = va_pkg::DW;
  localparam int unsigned QW = va_pkg::QW;

  logic                  accept;
  logic [2:0][DW-1:0]    a_in, b_in;
  logic                  f_vld, s_vld, d_vld;
  va_pkg::item_t         f_item, s_item, d_item;
  logic [va_pkg::SW-1:0] f_rad;
  logic [va_pkg::RW-1:0] s_root;
  logic [2:0][QW-1:0]    d_q;
  logic [2:0]            d_neg;

  va_pkg::item_t res_nxt, res_r;
  logic          vld_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign a_in   = {in_az, in_ay, in_ax};
  assign b_in   = {in_bz, in_by_comp, in_bx};

  va_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_func  (in_func),
    .in_a     (a_in),
    .in_b     (b_in),
    .in_k     (in_scalar_k),
    .out_vld  (f_vld),
    .out_item (f_item),
    .out_rad  (f_rad)
  );

  va_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .in_rad   (f_rad),
    .in_item  (f_item),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_item (s_item)
  );

  va_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s_vld),
    .in_root  (s_root),
    .in_item  (s_item),
    .out_vld  (d_vld),
    .out_q    (d_q),
    .out_neg  (d_neg),
    .out_item (d_item)
  );

  // sign, clip and special cases of the quotient lanes
  always_comb begin
    logic [2:0][DW-1:0] qv;
    logic               hit;
    logic               ov;
    qv      = '0;
    hit     = 1'b0;
    ov      = 1'b0;
    res_nxt = d_item;
    for (int i = 0; i < 3; i++) begin
      if (d_neg[i]) begin
        ov    = (|d_q[i][QW-1:DW]) || (d_q[i][DW-1] && (|d_q[i][DW-2:0]));
        qv[i] = ov ? va_pkg::S32_MIN : DW'(-d_q[i][DW-1:0]);
      end else begin
        ov    = |d_q[i][QW-1:DW-1];
        qv[i] = ov ? va_pkg::S32_MAX : d_q[i][DW-1:0];
      end
      hit = hit | ov;
    end
    case (d_item.func)
      va_pkg::FN_DIVIDE: begin
        if (d_item.k == '0) begin
          for (int i = 0; i < 3; i++) begin
            if (d_item.a[i][DW-1]) begin
              res_nxt.r[i] = va_pkg::S32_MIN;
            end else if (d_item.a[i] != '0) begin
              res_nxt.r[i] = va_pkg::S32_MAX;
            end else begin
              res_nxt.r[i] = '0;
            end
          end
          res_nxt.st = va_pkg::ST_DIVZ;
        end else begin
          res_nxt.r  = qv;
          res_nxt.st = hit ? va_pkg::ST_SAT : va_pkg::ST_OK;
        end
      end
      va_pkg::FN_NORM: begin
        if (d_item.a == '0) begin
          res_nxt.r  = d_item.a;
          res_nxt.st = va_pkg::ST_OK;
        end else begin
          res_nxt.r  = qv;
          res_nxt.st = hit ? va_pkg::ST_SAT : va_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid      = vld_r;
  assign out_rx         = res_r.r[0];
  assign out_ry         = res_r.r[1];
  assign out_rz         = res_r.r[2];
  assign out_rscalar    = res_r.rs;
  assign out_equal_flag = res_r.eq;
  assign out_status     = res_r.st;

endmodule

// ===== sim/vector3_alu_core_tb.sv =====
`timescale 1ns / 1ps

module vector3_alu_core_tb;

  localparam logic [31:0] S32_MAX = va_pkg::S32_MAX;
  localparam logic [31:0] S32_MIN = va_pkg::S32_MIN;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] ax, ay, az;
    logic [31:0] bx, by, bz;
    logic [31:0] k;
  } vec_req_t;

  typedef struct packed {
    logic [31:0] rx, ry, rz, rs;
    logic        eq;
    logic [1:0]  st;
  } vec_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_func;
  logic [31:0] in_ax, in_ay, in_az, in_bx, in_by_comp, in_bz, in_scalar_k;
  logic        out_valid;
  logic [31:0] out_rx, out_ry, out_rz, out_rscalar;
  logic        out_equal_flag;
  logic [1:0]  out_status;

  vec_req_t pending_reqs[$];
  vec_res_t expected_res[$];
  int       idle_pct;
  int       fail_cnt;
  int       n_driven;
  int       quiet_cycles;
  logic     took;

  vector3_alu_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by_comp(in_by_comp), .in_bz(in_bz), .in_scalar_k(in_scalar_k),
    .out_valid(out_valid), .out_rx(out_rx), .out_ry(out_ry), .out_rz(out_rz),
    .out_rscalar(out_rscalar), .out_equal_flag(out_equal_flag), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] clip(input logic signed [127:0] v, output logic hit);
    hit = 1'b0;
    if (v > 128'sd2147483647) begin
      hit = 1'b1;
      return S32_MAX;
    end
    if (v < -128'sd2147483648) begin
      hit = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic vec_res_t vec_op_predict(input vec_req_t q);
    vec_res_t res;
    logic signed [127:0] a[3], b[3], d[3], t[3], k, acc, m;
    logic hit, sat;
    a[0] = {{96{q.ax[31]}}, q.ax};
    a[1] = {{96{q.ay[31]}}, q.ay};
    a[2] = {{96{q.az[31]}}, q.az};
    b[0] = {{96{q.bx[31]}}, q.bx};
    b[1] = {{96{q.by[31]}}, q.by};
    b[2] = {{96{q.bz[31]}}, q.bz};
    k = {{96{q.k[31]}}, q.k};
    res = '0;
    sat = 1'b0;
    res.eq = (q.ax == q.bx) && (q.ay == q.by) && (q.az == q.bz);
    for (int i = 0; i < 3; i++) t[i] = '0;
    acc = '0;
    case (q.func)
      va_pkg::FN_ADD:    for (int i = 0; i < 3; i++) t[i] = a[i] + b[i];
      va_pkg::FN_SUB:    for (int i = 0; i < 3; i++) t[i] = a[i] - b[i];
      va_pkg::FN_NEGATE: for (int i = 0; i < 3; i++) t[i] = -a[i];
      va_pkg::FN_SCALE:  for (int i = 0; i < 3; i++) t[i] = (a[i] * k) >>> 16;
      va_pkg::FN_DIVIDE: begin
        for (int i = 0; i < 3; i++) begin
          if (k == 0) t[i] = a[i] > 0 ? 128'sd2147483647 : (a[i] < 0 ? -128'sd2147483648 : 0);
          else t[i] = (a[i] * 128'sd65536) / k;
        end
      end
      va_pkg::FN_DOT:    acc = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16;
      va_pkg::FN_CROSS: begin
        t[0] = (a[1] * b[2] - b[1] * a[2]) >>> 16;
        t[1] = (b[0] * a[2] - a[0] * b[2]) >>> 16;
        t[2] = (a[0] * b[1] - b[0] * a[1]) >>> 16;
      end
      va_pkg::FN_NORM: begin
        m = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        for (int i = 0; i < 3; i++) t[i] = (m == 0) ? a[i] : (a[i] * 128'sd65536) / m;
      end
      va_pkg::FN_MAG:    acc = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      va_pkg::FN_DIST: begin
        for (int i = 0; i < 3; i++) d[i] = a[i] - b[i];
        acc = floor_sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
      end
      default: ;
    endcase
    res.rx = clip(t[0], hit); sat |= hit;
    res.ry = clip(t[1], hit); sat |= hit;
    res.rz = clip(t[2], hit); sat |= hit;
    res.rs = clip(acc, hit);  sat |= hit;
    res.st = sat ? va_pkg::ST_SAT : va_pkg::ST_OK;
    if (q.func == va_pkg::FN_DIVIDE && k == 0) res.st = va_pkg::ST_DIVZ;
    return res;
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16);
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [3:0] f, input logic [31:0] ax, ay, az, bx, by, bz, k);
    vec_req_t q;
    q = '{func: f, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, k: k};
    pending_reqs.push_back(q);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    vec_req_t q;
    if (rst_n && (!start || took)) begin
      if (pending_reqs.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
      end else begin
        q = pending_reqs.pop_front();
        start       <= 1'b1;
        in_func     <= q.func;
        in_ax       <= q.ax;
        in_ay       <= q.ay;
        in_az       <= q.az;
        in_bx       <= q.bx;
        in_by_comp  <= q.by;
        in_bz       <= q.bz;
        in_scalar_k <= q.k;
        n_driven++;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vec_req_t q;
    vec_res_t e;
    took <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        q = '{func: in_func, ax: in_ax, ay: in_ay, az: in_az, bx: in_bx,
              by: in_by_comp, bz: in_bz, k: in_scalar_k};
        expected_res.push_back(vec_op_predict(q));
      end
      if (out_valid) begin
        if (expected_res.size() == 0) begin
          $display("%0t unexpected result: expected none actual rx %h", $time, out_rx);
          fail_cnt++;
        end else begin
          e = expected_res.pop_front();
          check_field("rx", e.rx, out_rx);
          check_field("ry", e.ry, out_ry);
          check_field("rz", e.rz, out_rz);
          check_field("rscalar", e.rs, out_rscalar);
          check_field("equal_flag", 32'(e.eq), 32'(out_equal_flag));
          check_field("status", 32'(e.st), 32'(out_status));
        end
      end
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] w[7];
    rst_n = 1'b0;
    start = 1'b0;
    took = 1'b0;
    in_func = va_pkg::FN_ADD;
    {in_ax, in_ay, in_az, in_bx, in_by_comp, in_bz, in_scalar_k} = '0;
    idle_pct = 26;
    fail_cnt = 0;
    n_driven = 0;
    quiet_cycles = 0;

    add_req(va_pkg::FN_ADD, S32_MAX, S32_MIN, 1, S32_MAX, S32_MIN, -1, 0);
    add_req(va_pkg::FN_SUB, S32_MIN, S32_MAX, 5, S32_MAX, S32_MIN, 5, 0);
    add_req(va_pkg::FN_NEGATE, S32_MIN, S32_MAX, 0, 0, 0, 0, 0);
    add_req(va_pkg::FN_SCALE, S32_MAX, S32_MIN, 32'hFFFF8000, 0, 0, 0, S32_MIN);
    add_req(va_pkg::FN_SCALE, 32'h00018000, 32'hFFFE7FFF, 3, 0, 0, 0, 32'h00008000);
    add_req(va_pkg::FN_DIVIDE, 7, -7, 0, 1, 2, 3, 0);
    add_req(va_pkg::FN_DIVIDE, S32_MAX, S32_MIN, 32'h00010000, 0, 0, 0, 1);
    add_req(va_pkg::FN_DIVIDE, S32_MIN, 100, -100, 0, 0, 0, -1);
    add_req(va_pkg::FN_DOT, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 0);
    add_req(va_pkg::FN_DOT, S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 0);
    add_req(va_pkg::FN_CROSS, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, 0);
    add_req(va_pkg::FN_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0);
    add_req(va_pkg::FN_NORM, 0, 0, 0, 5, 5, 5, 0);
    add_req(va_pkg::FN_NORM, 1, 0, 0, 0, 0, 0, 0);
    add_req(va_pkg::FN_NORM, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0);
    add_req(va_pkg::FN_MAG, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0);
    add_req(va_pkg::FN_MAG, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0);
    add_req(va_pkg::FN_DIST, S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 0);
    add_req(va_pkg::FN_DIST, 1, 2, 3, 1, 2, 3, 0);
    add_req(va_pkg::FN_EQUAL, 9, S32_MIN, S32_MAX, 9, S32_MIN, S32_MAX, 4);
    add_req(va_pkg::FN_EQUAL, 9, 8, 7, 9, 8, 6, 4);
    add_req(4'd11, 1, 1, 1, 1, 1, 1, 1);
    add_req(4'd15, 1, 2, 3, 4, 5, 6, 7);

    for (int n = 0; n < 450; n++) begin
      foreach (w[i]) w[i] = rnd_word();
      if ($urandom_range(0, 9) == 0) {w[3], w[4], w[5]} = {w[0], w[1], w[2]};
      if ($urandom_range(0, 11) == 0) w[6] = '0;
      add_req($urandom_range(0, 9) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10)),
              w[0], w[1], w[2], w[3], w[4], w[5], w[6]);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_reqs.size() != 0 || !took) begin
      @(posedge clk);
      if (n_driven > 160) idle_pct = 56;
      if (n_driven > 320) idle_pct = 0;
    end
    @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
